[sv/fds_pkg.sv]
// Shared types and constants of the fall detection sequencer.
package fds_pkg;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned PHASE_W    = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMPACT_TO     = 3'd0,
    REG_INACTIVITY_TO = 3'd1,
    REG_CONFIRM_TO    = 3'd2,
    REG_CHECK_TICKS   = 3'd3,
    REG_UPRIGHT_LIMIT = 3'd4
  } reg_idx_e;

  typedef enum logic [4:0] {
    ST_FREEFALL = 5'b00001,
    ST_IMPACT   = 5'b00010,
    ST_INACTIVE = 5'b00100,
    ST_CONFIRM  = 5'b01000,
    ST_FALL     = 5'b10000
  } phase_e;

  // Encoded phase as reported on the result word.
  localparam logic [PHASE_W-1:0] PHASE_FREEFALL = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_IMPACT   = 3'd1;
  localparam logic [PHASE_W-1:0] PHASE_INACTIVE = 3'd2;
  localparam logic [PHASE_W-1:0] PHASE_CONFIRM  = 3'd3;
  localparam logic [PHASE_W-1:0] PHASE_FALL     = 3'd4;

  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_FREEFALL   = 2'd1,
    CMD_IMPACT     = 2'd2,
    CMD_INACTIVITY = 2'd3
  } cmd_e;

  localparam logic [TICK_W-1:0]  RST_IMPACT_TO     = 16'd25;
  localparam logic [TICK_W-1:0]  RST_INACTIVITY_TO = 16'd250;
  localparam logic [TICK_W-1:0]  RST_CONFIRM_TO    = 16'd500;
  localparam logic [TICK_W-1:0]  RST_CHECK_TICKS   = 16'd5;
  localparam logic [COUNT_W-1:0] RST_UPRIGHT_LIMIT = 8'd10;

  typedef struct packed {
    logic [TICK_W-1:0]  impact_to;
    logic [TICK_W-1:0]  inactivity_to;
    logic [TICK_W-1:0]  confirm_to;
    logic [TICK_W-1:0]  check_ticks;
    logic [COUNT_W-1:0] upright_limit;
  } cfg_t;

  typedef struct packed {
    logic sensor_interrupt;
    logic is_upright;
    logic rearm;
  } tick_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    cmd_e               setup_command;
    logic               red_pulse;
    logic               green_pulse;
    logic               clear_interrupt;
    logic               fall_flag;
  } result_t;

endpackage

[sv/fds_cfg_regs.sv]
// Configuration register file of the fall detection sequencer.
module fds_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  output fds_pkg::cfg_t                    cfg_o
);

  fds_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (fds_pkg::reg_idx_e'(cfg_idx_i))
        fds_pkg::REG_IMPACT_TO:     cfg_d.impact_to     = cfg_wdata_i;
        fds_pkg::REG_INACTIVITY_TO: cfg_d.inactivity_to = cfg_wdata_i;
        fds_pkg::REG_CONFIRM_TO:    cfg_d.confirm_to    = cfg_wdata_i;
        fds_pkg::REG_CHECK_TICKS:   cfg_d.check_ticks   = cfg_wdata_i;
        fds_pkg::REG_UPRIGHT_LIMIT: cfg_d.upright_limit = cfg_wdata_i[fds_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.impact_to     <= fds_pkg::RST_IMPACT_TO;
      cfg_q.inactivity_to <= fds_pkg::RST_INACTIVITY_TO;
      cfg_q.confirm_to    <= fds_pkg::RST_CONFIRM_TO;
      cfg_q.check_ticks   <= fds_pkg::RST_CHECK_TICKS;
      cfg_q.upright_limit <= fds_pkg::RST_UPRIGHT_LIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/fds_core.sv]
// Phase state machine, tick timers and upright counter; result word is combinational.
module fds_core #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  fds_pkg::tick_t    tick_i,
  input  fds_pkg::cfg_t     cfg_i,
  output fds_pkg::result_t  result_o
);

  // Compare width covers both the timers and the 16-bit limits.
  localparam int unsigned CmpW = (TIMER_BITS > fds_pkg::TICK_W) ? TIMER_BITS : fds_pkg::TICK_W;

  fds_pkg::phase_e                 phase_q, phase_d;
  logic [TIMER_BITS-1:0]           event_timer_q, event_timer_d;
  logic [TIMER_BITS-1:0]           check_timer_q, check_timer_d;
  logic [fds_pkg::COUNT_W-1:0]     upright_count_q, upright_count_d;

  logic [TIMER_BITS-1:0]           event_inc, check_inc;
  logic [CmpW-1:0]                 event_ext, check_ext;
  logic                            impact_to_hit, inact_to_hit, confirm_to_hit, check_hit;
  fds_pkg::cmd_e                   cmd;
  logic                            red, green, clr;

  // Saturating increments, applied every tick before the phase logic.
  assign event_inc = (event_timer_q == '1) ? event_timer_q : event_timer_q + 1'b1;
  assign check_inc = (check_timer_q == '1) ? check_timer_q : check_timer_q + 1'b1;
  assign event_ext = CmpW'(event_inc);
  assign check_ext = CmpW'(check_inc);

  assign impact_to_hit  = event_ext >= CmpW'(cfg_i.impact_to);
  assign inact_to_hit   = event_ext >= CmpW'(cfg_i.inactivity_to);
  assign confirm_to_hit = event_ext >= CmpW'(cfg_i.confirm_to);
  assign check_hit      = check_ext >= CmpW'(cfg_i.check_ticks);

  always_comb begin
    phase_d         = phase_q;
    event_timer_d   = event_inc;
    check_timer_d   = check_inc;
    upright_count_d = upright_count_q;
    cmd             = fds_pkg::CMD_NONE;
    red             = 1'b0;
    green           = 1'b0;
    clr             = 1'b0;
    unique case (phase_q)
      fds_pkg::ST_FREEFALL: begin
        if (tick_i.sensor_interrupt) begin
          cmd           = fds_pkg::CMD_IMPACT;
          event_timer_d = '0;
          phase_d       = fds_pkg::ST_IMPACT;
        end
      end
      fds_pkg::ST_IMPACT: begin
        if (tick_i.sensor_interrupt) begin
          cmd     = fds_pkg::CMD_INACTIVITY;
          phase_d = fds_pkg::ST_INACTIVE;
        end else if (impact_to_hit) begin
          cmd     = fds_pkg::CMD_FREEFALL;
          phase_d = fds_pkg::ST_FREEFALL;
        end
      end
      fds_pkg::ST_INACTIVE: begin
        if (tick_i.sensor_interrupt) begin
          if (!tick_i.is_upright) begin
            red             = 1'b1;
            clr             = 1'b1;
            check_timer_d   = '0;
            upright_count_d = '0;
            phase_d         = fds_pkg::ST_CONFIRM;
          end else begin
            cmd     = fds_pkg::CMD_FREEFALL;
            phase_d = fds_pkg::ST_FREEFALL;
          end
        end else if (inact_to_hit) begin
          cmd     = fds_pkg::CMD_FREEFALL;
          phase_d = fds_pkg::ST_FREEFALL;
        end
      end
      fds_pkg::ST_CONFIRM: begin
        // timeout wins over the orientation check on the same tick
        if (confirm_to_hit) begin
          phase_d = fds_pkg::ST_FALL;
        end else if (check_hit) begin
          check_timer_d = '0;
          if (tick_i.is_upright) begin
            if (upright_count_q != '1) begin
              upright_count_d = upright_count_q + 1'b1;
            end
            // cancel test uses the count before increment
            if (upright_count_q >= cfg_i.upright_limit) begin
              green   = 1'b1;
              cmd     = fds_pkg::CMD_FREEFALL;
              phase_d = fds_pkg::ST_FREEFALL;
            end
          end else begin
            upright_count_d = '0;
          end
        end
      end
      fds_pkg::ST_FALL: begin
        if (tick_i.rearm) begin
          cmd     = fds_pkg::CMD_FREEFALL;
          phase_d = fds_pkg::ST_FREEFALL;
        end
      end
      default: begin
        cmd     = fds_pkg::CMD_FREEFALL;
        phase_d = fds_pkg::ST_FREEFALL;
      end
    endcase
  end

  always_comb begin
    result_o.setup_command   = cmd;
    result_o.red_pulse       = red;
    result_o.green_pulse     = green;
    result_o.clear_interrupt = clr;
    result_o.fall_flag       = (phase_d == fds_pkg::ST_FALL);
    unique case (phase_d)
      fds_pkg::ST_FREEFALL: result_o.phase = fds_pkg::PHASE_FREEFALL;
      fds_pkg::ST_IMPACT:   result_o.phase = fds_pkg::PHASE_IMPACT;
      fds_pkg::ST_INACTIVE: result_o.phase = fds_pkg::PHASE_INACTIVE;
      fds_pkg::ST_CONFIRM:  result_o.phase = fds_pkg::PHASE_CONFIRM;
      fds_pkg::ST_FALL:     result_o.phase = fds_pkg::PHASE_FALL;
      default:              result_o.phase = fds_pkg::PHASE_FREEFALL;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= fds_pkg::ST_FREEFALL;
      event_timer_q   <= '0;
      check_timer_q   <= '0;
      upright_count_q <= '0;
    end else if (advance_i) begin
      phase_q         <= phase_d;
      event_timer_q   <= event_timer_d;
      check_timer_q   <= check_timer_d;
      upright_count_q <= upright_count_d;
    end
  end

endmodule

[sv/fall_detect_sequencer.sv]
// Top level of the fall detection sequencer: input register, core and result register.
//
// One word per tick goes in and one result word comes out for each. A new word is taken
// every clock cycle while in_stall_o is low; a result is valid once its word has passed the
// input register and been loaded into the result register, where it sits until taken. The
// phase state and timers update on the same edge at which a word moves from the input
// register to the result register, so the rate is one word per cycle as long as the output
// side is not stalling. Configuration writes take effect on the next edge and should be
// made while no word is in flight.
module fall_detect_sequencer #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [fds_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [fds_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             sensor_interrupt_i,
  input  logic                             is_upright_i,
  input  logic                             rearm_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fds_pkg::PHASE_W-1:0]      phase_o,
  output logic [1:0]                       setup_command_o,
  output logic                             red_pulse_o,
  output logic                             green_pulse_o,
  output logic                             clear_interrupt_o,
  output logic                             fall_flag_o
);

  fds_pkg::cfg_t     cfg;
  fds_pkg::tick_t    tick_q;
  fds_pkg::result_t  result, result_q;
  logic              in_vld_q, out_vld_q;
  logic              out_free, advance, in_take;

  fds_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  fds_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .tick_i    (tick_q),
    .cfg_i     (cfg),
    .result_o  (result)
  );

  assign out_free   = !out_vld_q || !out_stall_i;
  assign advance    = in_vld_q && out_free;
  assign in_stall_o = in_vld_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (out_free) begin
        out_vld_q <= advance;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_q.sensor_interrupt <= sensor_interrupt_i;
      tick_q.is_upright       <= is_upright_i;
      tick_q.rearm            <= rearm_i;
    end
    if (advance) begin
      result_q <= result;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign phase_o           = result_q.phase;
  assign setup_command_o   = result_q.setup_command;
  assign red_pulse_o       = result_q.red_pulse;
  assign green_pulse_o     = result_q.green_pulse;
  assign clear_interrupt_o = result_q.clear_interrupt;
  assign fall_flag_o       = result_q.fall_flag;

endmodule

[tb/sv/fall_detect_sequencer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench of fall_detect_sequencer: directed tick table, then random ticks.
module fall_detect_sequencer_tb;

  localparam int unsigned IDLE_LIMIT  = 400;
  localparam int unsigned PHASE_TICKS = 74;
  localparam int unsigned NUM_SETS    = 9;
  // no register lives at this index; a write to it must change nothing
  localparam logic [fds_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    bit                             is_cfg;
    logic [fds_pkg::CFG_IDX_W-1:0]  idx;
    logic [fds_pkg::CFG_DATA_W-1:0] data;
    fds_pkg::tick_t                 tick;
    bit                             typed;
    fds_pkg::result_t               status;
  } plan_row_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [fds_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [fds_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic                           sensor_interrupt = 1'b0;
  logic                           is_upright = 1'b0;
  logic                           rearm = 1'b0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [fds_pkg::PHASE_W-1:0]    phase;
  logic [1:0]                     setup_command;
  logic                           red_pulse;
  logic                           green_pulse;
  logic                           clear_interrupt;
  logic                           fall_flag;

  // predictor state
  fds_pkg::cfg_t                  model_cfg;
  logic [fds_pkg::PHASE_W-1:0]    model_phase;
  logic [fds_pkg::TICK_W-1:0]     event_ticks;
  logic [fds_pkg::TICK_W-1:0]     check_ticks;
  logic [fds_pkg::COUNT_W-1:0]    upright_cnt;
  fds_pkg::result_t               pending_status_q[$];

  int unsigned           mismatches = 0;
  int unsigned           ticks_sent = 0;
  int unsigned           words_checked = 0;
  int unsigned           stall_left = 0;
  int unsigned           quiet_cycles = 0;
  bit                    gaps_on = 1'b1;

  always #4 clk_i = ~clk_i;

  fall_detect_sequencer dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .sensor_interrupt_i(sensor_interrupt),
    .is_upright_i      (is_upright),
    .rearm_i           (rearm),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .phase_o           (phase),
    .setup_command_o   (setup_command),
    .red_pulse_o       (red_pulse),
    .green_pulse_o     (green_pulse),
    .clear_interrupt_o (clear_interrupt),
    .fall_flag_o       (fall_flag)
  );

  function automatic fds_pkg::result_t advance_fall_state(fds_pkg::tick_t t);
    fds_pkg::result_t r;
    bit               cancel;
    r = '0;
    r.setup_command = fds_pkg::CMD_NONE;
    if (event_ticks != '1) event_ticks = event_ticks + 1'b1;
    if (check_ticks != '1) check_ticks = check_ticks + 1'b1;
    case (model_phase)
      fds_pkg::PHASE_FREEFALL: begin
        if (t.sensor_interrupt) begin
          r.setup_command = fds_pkg::CMD_IMPACT;
          event_ticks = '0;
          model_phase = fds_pkg::PHASE_IMPACT;
        end
      end
      fds_pkg::PHASE_IMPACT: begin
        if (t.sensor_interrupt) begin
          r.setup_command = fds_pkg::CMD_INACTIVITY;
          model_phase = fds_pkg::PHASE_INACTIVE;
        end else if (event_ticks >= model_cfg.impact_to) begin
          r.setup_command = fds_pkg::CMD_FREEFALL;
          model_phase = fds_pkg::PHASE_FREEFALL;
        end
      end
      fds_pkg::PHASE_INACTIVE: begin
        if (t.sensor_interrupt) begin
          if (!t.is_upright) begin
            r.red_pulse = 1'b1;
            r.clear_interrupt = 1'b1;
            check_ticks = '0;
            upright_cnt = '0;
            model_phase = fds_pkg::PHASE_CONFIRM;
          end else begin
            r.setup_command = fds_pkg::CMD_FREEFALL;
            model_phase = fds_pkg::PHASE_FREEFALL;
          end
        end else if (event_ticks >= model_cfg.inactivity_to) begin
          r.setup_command = fds_pkg::CMD_FREEFALL;
          model_phase = fds_pkg::PHASE_FREEFALL;
        end
      end
      fds_pkg::PHASE_CONFIRM: begin
        // timeout wins over an orientation check due on the same tick
        if (event_ticks >= model_cfg.confirm_to) begin
          model_phase = fds_pkg::PHASE_FALL;
        end else if (check_ticks >= model_cfg.check_ticks) begin
          check_ticks = '0;
          if (t.is_upright) begin
            cancel = (upright_cnt >= model_cfg.upright_limit);
            if (upright_cnt != '1) upright_cnt = upright_cnt + 1'b1;
            if (cancel) begin
              r.green_pulse = 1'b1;
              r.setup_command = fds_pkg::CMD_FREEFALL;
              model_phase = fds_pkg::PHASE_FREEFALL;
            end
          end else begin
            upright_cnt = '0;
          end
        end
      end
      fds_pkg::PHASE_FALL: begin
        if (t.rearm) begin
          r.setup_command = fds_pkg::CMD_FREEFALL;
          model_phase = fds_pkg::PHASE_FREEFALL;
        end
      end
      default: begin
        r.setup_command = fds_pkg::CMD_FREEFALL;
        model_phase = fds_pkg::PHASE_FREEFALL;
      end
    endcase
    r.phase = model_phase;
    r.fall_flag = (model_phase == fds_pkg::PHASE_FALL);
    return r;
  endfunction

  // random tick, mostly shaped to walk the sequence from the current phase
  function automatic fds_pkg::tick_t draw_tick();
    fds_pkg::tick_t t;
    if ($urandom_range(0, 9) < 2) begin
      t = fds_pkg::tick_t'(3'($urandom_range(0, 7)));
    end else begin
      t.sensor_interrupt = ($urandom_range(0, 2) == 0);
      t.is_upright = ($urandom_range(0, 1) == 1);
      t.rearm = ($urandom_range(0, 7) == 0);
      case (model_phase)
        fds_pkg::PHASE_INACTIVE: t.is_upright = ($urandom_range(0, 3) == 0);
        fds_pkg::PHASE_CONFIRM:  t.is_upright = ($urandom_range(0, 4) != 0);
        fds_pkg::PHASE_FALL:     t.rearm = ($urandom_range(0, 4) == 0);
        default: ;
      endcase
    end
    return t;
  endfunction

  function automatic plan_row_t tick_row(bit irq, bit up, bit rr);
    plan_row_t row;
    row.is_cfg = 1'b0;
    row.idx = '0;
    row.data = '0;
    row.tick = '{irq, up, rr};
    row.typed = 1'b0;
    row.status = '0;
    return row;
  endfunction

  function automatic plan_row_t status_row(bit irq, bit up, bit rr,
                                           logic [fds_pkg::PHASE_W-1:0] ph,
                                           fds_pkg::cmd_e cmd, bit red, bit green, bit clr,
                                           bit fall);
    plan_row_t row;
    row = tick_row(irq, up, rr);
    row.typed = 1'b1;
    row.status = '{ph, cmd, red, green, clr, fall};
    return row;
  endfunction

  function automatic plan_row_t cfg_row(logic [fds_pkg::CFG_IDX_W-1:0] idx,
                                        logic [fds_pkg::CFG_DATA_W-1:0] data);
    plan_row_t row;
    row = tick_row(1'b0, 1'b0, 1'b0);
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  task automatic send_tick(input fds_pkg::tick_t t, input bit typed,
                           input fds_pkg::result_t status);
    int unsigned      gap;
    fds_pkg::result_t predicted;
    gap = gaps_on ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    sensor_interrupt <= t.sensor_interrupt;
    is_upright <= t.is_upright;
    rearm <= t.rearm;
    do @(posedge clk_i); while (in_stall !== 1'b0);
    predicted = advance_fall_state(t);
    pending_status_q.push_back(typed ? status : predicted);
    ticks_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [fds_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fds_pkg::CFG_DATA_W-1:0] data);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      fds_pkg::REG_IMPACT_TO:     model_cfg.impact_to = data;
      fds_pkg::REG_INACTIVITY_TO: model_cfg.inactivity_to = data;
      fds_pkg::REG_CONFIRM_TO:    model_cfg.confirm_to = data;
      fds_pkg::REG_CHECK_TICKS:   model_cfg.check_ticks = data;
      fds_pkg::REG_UPRIGHT_LIMIT: model_cfg.upright_limit = data[fds_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic report_field(input string fld, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, fld, want, got);
      mismatches++;
    end
  endtask

  // result side: random stall after each word while gaps are on, compare against the oldest prediction
  always @(posedge clk_i) begin : rx_side
    fds_pkg::result_t want;
    int unsigned      n;
    if (rst_ni) begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (pending_status_q.size() == 0) begin
          $display("%0t ns: result word with no tick pending, phase %0d", $time, phase);
          mismatches++;
        end else begin
          want = pending_status_q.pop_front();
          report_field("phase", 4'(want.phase), 4'(phase));
          report_field("setup_command", 4'(want.setup_command), 4'(setup_command));
          report_field("red_pulse", 4'(want.red_pulse), 4'(red_pulse));
          report_field("green_pulse", 4'(want.green_pulse), 4'(green_pulse));
          report_field("clear_interrupt", 4'(want.clear_interrupt), 4'(clear_interrupt));
          report_field("fall_flag", 4'(want.fall_flag), 4'(fall_flag));
          words_checked++;
        end
        n = gaps_on ? $urandom_range(0, 12) : 0;
        stall_left <= n;
        out_stall <= (n != 0);
      end else if (stall_left > 1) begin
        stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
        stall_left <= 0;
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= IDLE_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    plan_row_t                      plan[$];
    logic [fds_pkg::CFG_DATA_W-1:0] v_imp, v_inact, v_conf, v_chk, v_lim;

    model_cfg = '{fds_pkg::RST_IMPACT_TO, fds_pkg::RST_INACTIVITY_TO,
                  fds_pkg::RST_CONFIRM_TO, fds_pkg::RST_CHECK_TICKS,
                  fds_pkg::RST_UPRIGHT_LIMIT};
    model_phase = fds_pkg::PHASE_FREEFALL;
    event_ticks = '0;
    check_ticks = '0;
    upright_cnt = '0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: quiet tick, free fall, impact, upright at inactivity
    plan.push_back(status_row(0, 0, 0, fds_pkg::PHASE_FREEFALL, fds_pkg::CMD_NONE,
                              0, 0, 0, 0));
    plan.push_back(status_row(1, 0, 0, fds_pkg::PHASE_IMPACT, fds_pkg::CMD_IMPACT,
                              0, 0, 0, 0));
    plan.push_back(tick_row(1, 1, 0));
    plan.push_back(tick_row(1, 1, 0));
    plan.push_back(cfg_row(fds_pkg::REG_IMPACT_TO, 16'd0));
    plan.push_back(cfg_row(fds_pkg::REG_INACTIVITY_TO, 16'd3));
    plan.push_back(cfg_row(fds_pkg::REG_CONFIRM_TO, 16'd10));
    plan.push_back(cfg_row(fds_pkg::REG_CHECK_TICKS, 16'd0));
    plan.push_back(cfg_row(fds_pkg::REG_UPRIGHT_LIMIT, 16'd0));
    plan.push_back(cfg_row(REG_SPARE, 16'hFFFF));
    // zero impact timeout: back to free fall on the next quiet tick; rearm ignored
    plan.push_back(tick_row(1, 0, 1));
    plan.push_back(status_row(0, 0, 0, fds_pkg::PHASE_FREEFALL, fds_pkg::CMD_FREEFALL,
                              0, 0, 0, 0));
    // inactivity timeout
    plan.push_back(tick_row(1, 0, 0));
    plan.push_back(tick_row(1, 0, 0));
    plan.push_back(tick_row(0, 0, 1));
    plan.push_back(tick_row(0, 1, 0));
    // confirm, then cancel at the first upright check with a zero limit
    plan.push_back(tick_row(1, 1, 1));
    plan.push_back(tick_row(1, 1, 0));
    plan.push_back(tick_row(1, 0, 0));
    plan.push_back(tick_row(0, 1, 0));
    plan.push_back(cfg_row(fds_pkg::REG_UPRIGHT_LIMIT, 16'h00FF));
    plan.push_back(cfg_row(fds_pkg::REG_CONFIRM_TO, 16'd7));
    // upright run broken by a tilted check, then timeout on a check tick, then rearm
    plan.push_back(tick_row(1, 0, 0));
    plan.push_back(tick_row(1, 0, 0));
    plan.push_back(tick_row(1, 0, 0));
    plan.push_back(tick_row(0, 1, 0));
    plan.push_back(tick_row(1, 1, 1));
    plan.push_back(tick_row(0, 0, 0));
    plan.push_back(tick_row(0, 1, 0));
    plan.push_back(tick_row(0, 1, 0));
    plan.push_back(tick_row(1, 1, 0));
    plan.push_back(status_row(0, 0, 1, fds_pkg::PHASE_FREEFALL, fds_pkg::CMD_FREEFALL,
                              0, 0, 0, 0));
    plan.push_back(tick_row(0, 0, 1));

    foreach (plan[i]) begin
      if (plan[i].is_cfg) write_cfg(plan[i].idx, plan[i].data);
      else send_tick(plan[i].tick, plan[i].typed, plan[i].status);
    end

    for (int p = 0; p < NUM_SETS; p++) begin
      case (p)
        3: begin
          v_imp = '0; v_inact = '0; v_conf = '0; v_chk = '0; v_lim = '0;
        end
        4: begin
          v_imp = fds_pkg::CFG_DATA_W'($urandom_range(0, 65535));
          v_inact = fds_pkg::CFG_DATA_W'($urandom_range(0, 65535));
          v_conf = fds_pkg::CFG_DATA_W'($urandom_range(0, 65535));
          v_chk = fds_pkg::CFG_DATA_W'($urandom_range(0, 65535));
          v_lim = fds_pkg::CFG_DATA_W'($urandom_range(0, 65535));
        end
        5: begin
          v_imp = '1; v_inact = '1; v_conf = '1; v_chk = '1; v_lim = 16'h00FF;
        end
        8: begin
          v_imp = fds_pkg::RST_IMPACT_TO;
          v_inact = fds_pkg::RST_INACTIVITY_TO;
          v_conf = fds_pkg::RST_CONFIRM_TO;
          v_chk = fds_pkg::RST_CHECK_TICKS;
          v_lim = fds_pkg::CFG_DATA_W'(fds_pkg::RST_UPRIGHT_LIMIT);
        end
        default: begin
          v_imp = fds_pkg::CFG_DATA_W'($urandom_range(0, 8));
          v_inact = fds_pkg::CFG_DATA_W'($urandom_range(0, 16));
          v_conf = fds_pkg::CFG_DATA_W'($urandom_range(0, 48));
          v_chk = fds_pkg::CFG_DATA_W'($urandom_range(0, 5));
          v_lim = fds_pkg::CFG_DATA_W'($urandom_range(0, 6));
        end
      endcase
      // set 6 keeps the all-max settings of set 5 and runs back to back
      if (p != 6) begin
        write_cfg(fds_pkg::REG_IMPACT_TO, v_imp);
        write_cfg(fds_pkg::REG_INACTIVITY_TO, v_inact);
        write_cfg(fds_pkg::REG_CONFIRM_TO, v_conf);
        write_cfg(fds_pkg::REG_CHECK_TICKS, v_chk);
        write_cfg(fds_pkg::REG_UPRIGHT_LIMIT, v_lim);
      end
      gaps_on = (p % 3 != 2) && (p != 6);
      for (int k = 0; k < PHASE_TICKS; k++) send_tick(draw_tick(), 1'b0, '0);
    end

    gaps_on = 1'b1;
    wait_idle();

    $display("Checked %0d result words from %0d ticks: directed table plus %0d register sets,",
             words_checked, ticks_sent, NUM_SETS);
    $display("including all-zero, all-max and random 16-bit settings, with and without stalls");
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
sv/fds_pkg.sv
sv/fds_cfg_regs.sv
sv/fds_core.sv
sv/fall_detect_sequencer.sv
tb/sv/fall_detect_sequencer_tb.sv
